[sv/psc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for the pressure sleep controller
// Widths, register indexes and the state/result bundles used across modules.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int NUM_SENSORS = 19;
	localparam int SAMPLE_BITS = 12;
	localparam int SAMPLE_W    = 12;
	localparam int THRESH_W    = 12;
	localparam int LOW_CNT_W   = 5;
	localparam int LEVEL_W     = 15;
	localparam int SUMMARY_W   = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [SAMPLE_W-1:0]  SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [LOW_CNT_W-1:0] LOW_CNT_MAX = LOW_CNT_W'(NUM_SENSORS);
	localparam logic [LEVEL_W-1:0]   LEVEL_FALL  = LEVEL_W'(4);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_COUNT_NEEDED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_LIMIT      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_PERIOD   = 2'd3;

	// configuration register reset values
	localparam logic [THRESH_W-1:0]  RST_LOW_THRESHOLD    = 12'd64;
	localparam logic [LOW_CNT_W-1:0] RST_LOW_COUNT_NEEDED = 5'd15;
	localparam logic [LEVEL_W-1:0]   RST_SLEEP_LIMIT      = 15'd300;
	localparam logic [SUMMARY_W-1:0] RST_SUMMARY_PERIOD   = 16'd60;

	typedef struct packed {
		logic [THRESH_W-1:0]  low_threshold;
		logic [LOW_CNT_W-1:0] low_count_needed;
		logic [LEVEL_W-1:0]   sleep_limit;
		logic [SUMMARY_W-1:0] summary_period;
	} cfg_t;

	typedef struct packed {
		logic [LOW_CNT_W-1:0] frame_low_count;
		logic [LEVEL_W-1:0]   inactivity_count;
		logic [SUMMARY_W-1:0] summary_count;
		logic                 sleeping;
	} state_t;

	typedef struct packed {
		logic                 summary_flush;
		logic                 sleep_enter;
		logic                 wake;
		logic                 asleep;
		logic [LOW_CNT_W-1:0] low_count;
		logic [LEVEL_W-1:0]   inactivity_level;
	} result_t;

endpackage

[sv/psc_frame_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_frame_eval: per-sample update and end-of-frame decision
// Counts low samples and, on the last sample, works out flush, level and mode.
// ----------------------------------------------------------------------------
module psc_frame_eval
	import psc_pkg::*;
(
	input  cfg_t                cfg,
	input  state_t              cur,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last_in_frame,
	input  logic                link_connected,
	output state_t              nxt,
	output result_t             res
);

	logic [LOW_CNT_W-1:0] n;
	logic                 idle;
	logic [SUMMARY_W-1:0] sc_inc;
	logic                 periodic;
	logic [SUMMARY_W-1:0] sc_mid;
	logic [LEVEL_W-1:0]   level_new;
	logic                 enter;

	always_comb begin
		n = cur.frame_low_count;
		if (((sample & SAMPLE_MASK) < cfg.low_threshold) && (n < LOW_CNT_MAX)) begin
			n = n + LOW_CNT_W'(1);
		end
		idle = (n >= cfg.low_count_needed);

		sc_inc   = cur.summary_count + SUMMARY_W'(1);
		periodic = (sc_inc >= cfg.summary_period);
		sc_mid   = periodic ? '0 : sc_inc;

		priority if (link_connected) begin
			level_new = '0;
		end else if (idle) begin
			level_new = (cur.inactivity_count >= cfg.sleep_limit) ? cfg.sleep_limit
				: cur.inactivity_count + LEVEL_W'(1);
		end else begin
			level_new = (cur.inactivity_count > LEVEL_FALL)
				? cur.inactivity_count - LEVEL_FALL : '0;
		end
		enter = (level_new >= cfg.sleep_limit);

		// defaults: mid-frame sample, only the count moves
		nxt                 = cur;
		nxt.frame_low_count = n;
		res                 = '0;
		res.low_count       = n;

		if (last_in_frame) begin
			nxt.frame_low_count = '0;
			if (cur.sleeping) begin
				// wake on the first busy frame, nothing else changes
				nxt.sleeping = idle;
				res.wake     = !idle;
			end else begin
				nxt.inactivity_count = level_new;
				nxt.summary_count    = (enter && (sc_mid != '0)) ? '0 : sc_mid;
				nxt.sleeping         = enter;
				res.summary_flush    = periodic || (enter && (sc_mid != '0));
				res.sleep_enter      = enter;
			end
			res.asleep           = nxt.sleeping;
			res.inactivity_level = nxt.inactivity_count;
		end
	end

endmodule

[sv/pressure_inactivity_sleep_control_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_inactivity_sleep_control_core: pressure frame sleep controller
// Counts unloaded sensors per frame and tracks inactivity, summary flushes
// and sleep/wake mode, one result per frame.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | sample, last_in_frame, link_connected
//  out     | out_valid / out_ready| summary_flush, sleep_enter, wake, asleep,
//          |                      | low_count, inactivity_level
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample transfer per cycle while in_ready is high. A sample lands in the
// input register and is evaluated in the following cycle; a frame's result is
// registered when the last sample leaves the input stage, once the slot is free.
// Reset clears all counters, the mode (awake) and the config registers to
// their defaults. A stalled result holds the last sample of the next frame in
// the input register; mid-frame samples keep flowing past a waiting result.
// ----------------------------------------------------------------------------
module pressure_inactivity_sleep_control_core
	import psc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  last_in_frame,
	input  logic                  link_connected,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  summary_flush,
	output logic                  sleep_enter,
	output logic                  wake,
	output logic                  asleep,
	output logic [LOW_CNT_W-1:0]  low_count,
	output logic [LEVEL_W-1:0]    inactivity_level,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// input stage
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                last_s1;
	logic                link_s1;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    advance_s1;
	logic    in_fire;

	// a last sample may only leave the input stage when the result slot is free
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign in_fire    = in_valid && in_ready;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload: capture on every transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= sample;
			last_s1   <= last_in_frame;
			link_s1   <= link_connected;
		end
	end

	// configuration registers, to be written only while the block is quiet; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold    <= RST_LOW_THRESHOLD;
			cfg_q.low_count_needed <= RST_LOW_COUNT_NEEDED;
			cfg_q.sleep_limit      <= RST_SLEEP_LIMIT;
			cfg_q.summary_period   <= RST_SUMMARY_PERIOD;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOW_THRESHOLD:    cfg_q.low_threshold    <= cfg_data[THRESH_W-1:0];
				REG_LOW_COUNT_NEEDED: cfg_q.low_count_needed <= cfg_data[LOW_CNT_W-1:0];
				REG_SLEEP_LIMIT:      cfg_q.sleep_limit      <= cfg_data[LEVEL_W-1:0];
				REG_SUMMARY_PERIOD:   cfg_q.summary_period   <= cfg_data[SUMMARY_W-1:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	psc_frame_eval u_eval (
		.cfg            (cfg_q),
		.cur            (state_q),
		.sample         (sample_s1),
		.last_in_frame  (last_s1),
		.link_connected (link_s1),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	// advance the frame state once per evaluated sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register: load on a frame end, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign summary_flush    = res_q.summary_flush;
	assign sleep_enter      = res_q.sleep_enter;
	assign wake             = res_q.wake;
	assign asleep           = res_q.asleep;
	assign low_count        = res_q.low_count;
	assign inactivity_level = res_q.inactivity_level;

endmodule
